/* rtl/pts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic tick task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_TICK       = 2'd0;
   localparam logic [1:0] CMD_INSERT     = 2'd1;
   localparam logic [1:0] CMD_SET_ENABLE = 2'd2;
   localparam logic [1:0] CMD_REMOVE     = 2'd3;

   // result status codes
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   // insert flag bit positions
   localparam int FLAG_EN   = 0;
   localparam int FLAG_ONCE = 1;

   localparam int MASK_W = 16;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // remainder unit, one quotient bit a cycle
   localparam int               DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [31:0] period;
      logic [31:0] offset;
      logic [1:0]  flags;
      logic        enable;
   } pts_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic              status;
      logic [3:0]        slot_out;
   } pts_rsp_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_INSERT,
      OP_SET_EN,
      OP_REMOVE,
      OP_FAIL
   } pts_op_code_type;

   typedef struct packed {
      pts_op_code_type op;
      logic [3:0]      slot;
      logic [31:0]     period;
      logic [31:0]     offset;
      logic [1:0]      flags;
      logic            enable;
   } pts_op_type;

   // one slot table entry: count is ticks left until the next match
   typedef struct packed {
      logic [31:0] period;
      logic [31:0] offset;
      logic [31:0] count;
   } pts_ent_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } pts_div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] rem;
   } pts_div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TICK,
      BK_DIV,
      BK_ADJ,
      BK_DONE
   } pts_bk_state_type;

endpackage

/* rtl/pts_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_div
// Restoring remainder unit, 32 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pts_div (
   input  logic                     clock,
   input  logic                     reset,
   input  pts_pkg::pts_div_req_type req,
   output pts_pkg::pts_div_rsp_type rsp
);
   import pts_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic [31:0]          dsr_ff, dsr_in;
   logic [32:0]          shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[31]};
      if (busy_ff) begin
         // partial remainder stays below the divisor, so 32 bits suffice
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 32'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[31:0];
         end
         quo_in = {quo_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* rtl/pts_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_fifo
// Short work queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module pts_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  pts_pkg::pts_op_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output pts_pkg::pts_op_type out_data
);
   import pts_pkg::*;

   pts_op_type        ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   assign in_stall  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* rtl/pts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_front
// Takes request items, decodes the command and rejects what needs no state.
// ----------------------------------------------------------------------------
module pts_front #(
   parameter int SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pts_pkg::pts_req_type req_data,
   output logic                 q_valid,
   input  logic                 q_stall,
   output pts_pkg::pts_op_type  q_data
);
   import pts_pkg::*;

   logic       op_valid_ff, op_valid_in;
   pts_op_type op_ff, op_in;
   pts_op_type cls;

   always_comb begin
      cls.slot   = req_data.slot;
      cls.period = req_data.period;
      cls.offset = req_data.offset;
      cls.flags  = req_data.flags;
      cls.enable = req_data.enable;
      unique case (req_data.cmd)
         CMD_TICK:   cls.op = OP_TICK;
         CMD_INSERT: cls.op = (req_data.period == '0) ? OP_FAIL : OP_INSERT;
         CMD_SET_ENABLE: begin
            cls.op = (32'(req_data.slot) >= SLOTS) ? OP_FAIL : OP_SET_EN;
         end
         CMD_REMOVE: begin
            cls.op = (32'(req_data.slot) >= SLOTS) ? OP_FAIL : OP_REMOVE;
         end
         default:    cls.op = OP_FAIL;
      endcase
   end

   assign req_stall = op_valid_ff && q_stall;

   always_comb begin
      op_valid_in = op_valid_ff;
      op_in       = op_ff;
      if (!req_stall) begin
         op_valid_in = req_valid;
         op_in       = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign q_valid = op_valid_ff;
   assign q_data  = op_ff;

endmodule

/* rtl/pts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_back
// Executes queued operations on the slot table and holds the result register.
// ----------------------------------------------------------------------------
module pts_back #(
   parameter int SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_stall,
   input  pts_pkg::pts_op_type  q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pts_pkg::pts_rsp_type rsp_data
);
   import pts_pkg::*;

   localparam int            IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int            CW       = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS);
   localparam int            EW       = $bits(pts_ent_type);

   pts_bk_state_type  state_ff, state_in;
   pts_op_type        op_ff, op_in;
   logic [31:0]       tick_ff, tick_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  enab_ff, enab_in;
   logic [SLOTS-1:0]  once_ff, once_in;
   logic [SLOTS-1:0]  reach_ff, reach_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   pts_rsp_type       res_ff, res_in;
   logic [IW-1:0]     ins_idx_ff, ins_idx_in;
   logic [32:0]       diff_ff, diff_in;
   logic              out_valid_ff, out_valid_in;
   pts_rsp_type       out_data_ff, out_data_in;

   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   pts_ent_type       ram_wr_data;
   logic [IW-1:0]     ram_rd_addr;
   logic [EW-1:0]     ram_rd_data;

   pts_div_req_type   div_req;
   pts_div_rsp_type   div_rsp;

   logic              free_any;
   logic [IW-1:0]     free_idx;
   logic [IW-1:0]     slot_idx;
   pts_ent_type       tk_ent;
   logic              tk_hit;
   logic [31:0]       tk_base;
   logic [31:0]       tk_next;

   pts_ram #(
      .WIDTH(EW),
      .DEPTH(SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_any = 1'b1;
            free_idx = IW'(k);
         end
      end
   end

   assign slot_idx = IW'(q_data.slot);

   // per slot tick step on the entry read last cycle
   always_comb begin
      tk_ent  = pts_ent_type'(ram_rd_data);
      tk_hit  = valid_ff[pend_idx_ff] && enab_ff[pend_idx_ff] && reach_ff[pend_idx_ff]
                && (tk_ent.count == '0);
      tk_base = (tk_ent.count == '0) ? tk_ent.period : tk_ent.count;
      // counter wraps to zero after this tick, so every phase restarts
      tk_next = (tick_ff == '1) ? tk_ent.offset : (tk_base - 32'd1);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      enab_in      = enab_ff;
      once_in      = once_ff;
      reach_in     = reach_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      mask_in      = mask_ff;
      res_in       = res_ff;
      ins_idx_in   = ins_idx_ff;
      diff_in      = diff_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      q_stall          = (state_ff != BK_IDLE);
      ram_wr_en        = 1'b0;
      ram_wr_addr      = pend_idx_ff;
      ram_wr_data      = tk_ent;
      ram_rd_addr      = issue_ff[IW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = tick_ff;
      div_req.divisor  = q_data.period;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               op_in = q_data;
               unique case (q_data.op)
                  OP_TICK: begin
                     issue_in = '0;
                     pend_in  = 1'b0;
                     mask_in  = '0;
                     state_in = BK_TICK;
                  end
                  OP_INSERT: begin
                     if (free_any) begin
                        ins_idx_in    = free_idx;
                        div_req.start = 1'b1;
                        state_in      = BK_DIV;
                     end else begin
                        res_in   = '{fired_mask: '0, status: ST_FAIL, slot_out: '0};
                        state_in = BK_DONE;
                     end
                  end
                  OP_SET_EN: begin
                     if (valid_ff[slot_idx]) begin
                        enab_in[slot_idx] = q_data.enable;
                        res_in = '{fired_mask: '0, status: ST_OK, slot_out: '0};
                     end else begin
                        res_in = '{fired_mask: '0, status: ST_FAIL, slot_out: '0};
                     end
                     state_in = BK_DONE;
                  end
                  OP_REMOVE: begin
                     if (valid_ff[slot_idx]) begin
                        valid_in[slot_idx] = 1'b0;
                        enab_in[slot_idx]  = 1'b0;
                        res_in = '{fired_mask: '0, status: ST_OK, slot_out: '0};
                     end else begin
                        res_in = '{fired_mask: '0, status: ST_FAIL, slot_out: '0};
                     end
                     state_in = BK_DONE;
                  end
                  default: begin
                     res_in   = '{fired_mask: '0, status: ST_FAIL, slot_out: '0};
                     state_in = BK_DONE;
                  end
               endcase
            end
         end
         BK_TICK: begin
            if (issue_ff != LAST_CNT) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (tk_hit && once_ff[pend_idx_ff]) begin
                  enab_in[pend_idx_ff] = 1'b0;
               end
               for (int k = 0; k < MASK_W; k++) begin
                  if (tk_hit && (k < SLOTS) && (pend_idx_ff == IW'(k))) begin
                     mask_in[k] = 1'b1;
                  end
               end
               if (valid_ff[pend_idx_ff]) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_addr       = pend_idx_ff;
                  ram_wr_data.count = tk_next;
               end
            end
            if ((issue_ff == LAST_CNT) && !pend_ff) begin
               tick_in  = tick_ff + 32'd1;
               res_in   = '{fired_mask: mask_ff, status: ST_OK, slot_out: '0};
               state_in = BK_DONE;
            end
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               diff_in              = {1'b0, op_ff.offset} - {1'b0, div_rsp.rem};
               reach_in[ins_idx_ff] = (op_ff.offset < op_ff.period);
               state_in             = BK_ADJ;
            end
         end
         BK_ADJ: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = ins_idx_ff;
            ram_wr_data.period = op_ff.period;
            ram_wr_data.offset = op_ff.offset;
            ram_wr_data.count  = diff_ff[32] ? (diff_ff[31:0] + op_ff.period)
                                             : diff_ff[31:0];
            valid_in[ins_idx_ff] = 1'b1;
            enab_in[ins_idx_ff]  = op_ff.flags[FLAG_EN];
            once_in[ins_idx_ff]  = op_ff.flags[FLAG_ONCE];
            res_in   = '{fired_mask: '0, status: ST_OK, slot_out: 4'(ins_idx_ff)};
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         tick_ff      <= '0;
         valid_ff     <= '0;
         enab_ff      <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         enab_ff      <= enab_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      once_ff     <= once_in;
      reach_ff    <= reach_in;
      pend_idx_ff <= pend_idx_in;
      mask_ff     <= mask_in;
      res_ff      <= res_in;
      ins_idx_ff  <= ins_idx_in;
      diff_ff     <= diff_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/periodic_tick_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_tick_task_scheduler
// Slot table of periodic tasks driven by tick items, one result per item.
// ----------------------------------------------------------------------------
// usage
//   req channel: one command item (tick, insert, set enable, remove) per
//   handshake, taken when req_valid is high and req_stall is low
//   rsp channel: exactly one result item per request, in request order,
//   taken when rsp_valid is high and rsp_stall is low
//   a front stage decodes items and rejects zero periods and bad slot
//   indices, then a two entry queue feeds the back end that owns the table
//   tick: walks the slot table through the table RAM, one slot a cycle
//   insert: the phase of the new slot is tick count mod period, worked out
//   by a bit-serial remainder unit
//   set enable, remove and rejected items: decided in the idle state, then
//   the result goes out from the done state
//   reset clears the tick counter, all valid and enable bits and every
//   handshake register; the table RAM needs no clearing pass
//   a stalled result waits in the output register while the back end
//   already starts on the next queued item; it holds only at its finish
// ----------------------------------------------------------------------------
module periodic_tick_task_scheduler #(
   parameter int SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pts_pkg::pts_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pts_pkg::pts_rsp_type rsp_data
);
   import pts_pkg::*;

   // classified items into the queue
   logic       fr_valid;
   logic       fr_stall;
   pts_op_type fr_data;

   // queue to the back end
   logic       bk_valid;
   logic       bk_stall;
   pts_op_type bk_data;

   pts_front #(
      .SLOTS(SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (fr_valid),
      .q_stall   (fr_stall),
      .q_data    (fr_data)
   );

   pts_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_stall  (fr_stall),
      .in_data   (fr_data),
      .out_valid (bk_valid),
      .out_stall (bk_stall),
      .out_data  (bk_data)
   );

   // slot table, tick counter and result register live here
   pts_back #(
      .SLOTS(SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bk_valid),
      .q_stall   (bk_stall),
      .q_data    (bk_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/pts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Port level checks for the periodic tick task scheduler.
// ----------------------------------------------------------------------------
module pts_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input pts_pkg::pts_rsp_type rsp_data
);
   import pts_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // both channels come out of reset quiet and open
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake not cleared by reset");

   // a failure carries no fired bits and no slot
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FAIL) |->
         (rsp_data.fired_mask == '0) && (rsp_data.slot_out == '0))
      else $error("failure item with mask or slot set");

   // a result with fired bits is a tick and reports no slot
   a_tick_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.fired_mask != '0) |->
         (rsp_data.status == ST_OK) && (rsp_data.slot_out == '0))
      else $error("tick item with status or slot set");

endmodule

bind periodic_tick_task_scheduler pts_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* sim/pts_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_result_checker
// Watches both channels of the scheduler and predicts each result from its
// own copy of the slot table and tick counter. Every result taken on the rsp
// channel is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pts_result_checker #(
   parameter int SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  pts_pkg::pts_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pts_pkg::pts_rsp_type rsp_data,
   output int                   fail_count,
   output int                   results_pending
);
   import pts_pkg::*;

   localparam int PRINT_LIMIT = 100;

   // shadow scheduler state
   logic [31:0] tick_cnt;
   logic        slot_used [SLOTS];
   logic        slot_on   [SLOTS];
   logic        slot_once [SLOTS];
   logic [31:0] slot_per  [SLOTS];
   logic [31:0] slot_ofs  [SLOTS];

   pts_rsp_type awaited_results [$];
   pts_rsp_type oldest;
   int          mismatches = 0;

   function automatic void clear_table();
      tick_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_on[i]   = 1'b0;
         slot_once[i] = 1'b0;
         slot_per[i]  = '0;
         slot_ofs[i]  = '0;
      end
   endfunction

   // applies one command to the shadow table and returns its result
   function automatic pts_rsp_type run_command(input pts_req_type c);
      pts_rsp_type r;
      logic        placed;
      r      = '0;
      placed = 1'b0;
      case (c.cmd)
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_on[i] && slot_per[i] != 0 &&
                   (tick_cnt % slot_per[i]) == slot_ofs[i]) begin
                  if (i < MASK_W) r.fired_mask[i] = 1'b1;
                  if (slot_once[i]) slot_on[i] = 1'b0;
               end
            end
            tick_cnt = tick_cnt + 32'd1;
            r.status = ST_OK;
         end
         CMD_INSERT: begin
            r.status = ST_FAIL;
            if (c.period != 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!placed && !slot_used[i]) begin
                     placed       = 1'b1;
                     slot_used[i] = 1'b1;
                     slot_per[i]  = c.period;
                     slot_ofs[i]  = c.offset;
                     slot_on[i]   = c.flags[FLAG_EN];
                     slot_once[i] = c.flags[FLAG_ONCE];
                     r.status     = ST_OK;
                     r.slot_out   = 4'(i);
                  end
               end
            end
         end
         default: begin
            // set enable and remove share the slot check
            if (int'(c.slot) >= SLOTS || !slot_used[c.slot]) begin
               r.status = ST_FAIL;
            end else begin
               if (c.cmd == CMD_SET_ENABLE) begin
                  slot_on[c.slot] = c.enable;
               end else begin
                  slot_used[c.slot] = 1'b0;
                  slot_on[c.slot]   = 1'b0;
               end
               r.status = ST_OK;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         awaited_results.delete();
      end else begin
         // result first: it always belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_data));
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_data.fired_mask !== oldest.fired_mask)
                  report_mismatch($sformatf("fired_mask got %h want %h",
                                            rsp_data.fired_mask, oldest.fired_mask));
               if (rsp_data.status !== oldest.status)
                  report_mismatch($sformatf("status got %b want %b",
                                            rsp_data.status, oldest.status));
               if (rsp_data.slot_out !== oldest.slot_out)
                  report_mismatch($sformatf("slot_out got %h want %h",
                                            rsp_data.slot_out, oldest.slot_out));
            end
         end
         if (req_valid && !req_stall) awaited_results.push_back(run_command(req_data));
      end
      fail_count      <= mismatches;
      results_pending <= awaited_results.size();
   end

endmodule

/* sim/tb_periodic_tick_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_tick_task_scheduler
// Drives command items into the scheduler with random gaps and result stalls,
// a directed opening and a long random run; the checker beside the block
// predicts and compares, this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_periodic_tick_task_scheduler;
   import pts_pkg::*;

   localparam int SLOTS        = 16;
   localparam int RAND_ITEMS   = 1250;
   localparam int DRAIN_CYCLES = 100;   // well above the slowest insert latency
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

   // insert flag values built from the package bit positions
   localparam logic [1:0] F_OFF  = 2'b00;
   localparam logic [1:0] F_EN   = 2'b01 << FLAG_EN;
   localparam logic [1:0] F_ONCE = 2'b01 << FLAG_ONCE;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pts_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pts_rsp_type rsp_data;

   int          fail_count;
   int          results_pending;

   // stimulus side bookkeeping
   logic [31:0] ticks_sent    = '0;  // ticks accepted so far, used to aim big phases
   bit          send_fast     = 1'b0;
   bit          recv_fast     = 1'b0;
   int          results_taken = 0;

   periodic_tick_task_scheduler #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   pts_result_checker #(
      .SLOTS(SLOTS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .results_pending(results_pending)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // single reset pulse at the start, never again
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // builds one request item from the given fields; callers pass random bits in some unused fields
   function automatic pts_req_type make_item(input logic [1:0] cmd, input logic [3:0] slot,
                                             input logic [31:0] period,
                                             input logic [31:0] offset,
                                             input logic [1:0] flags, input logic enable);
      pts_req_type it;
      it.cmd    = cmd;
      it.slot   = slot;
      it.period = period;
      it.offset = offset;
      it.flags  = flags;
      it.enable = enable;
      return it;
   endfunction

   // random command, weighted by the current traffic profile
   function automatic pts_req_type random_item(input int profile);
      pts_req_type it;
      int          pick;
      int          kind;
      int          t_tick;
      int          t_ins;
      int          t_en;
      it.slot   = 4'($urandom_range(0, 15));
      it.period = $urandom();
      it.offset = $urandom();
      it.flags  = 2'($urandom_range(0, 3));
      it.enable = 1'($urandom_range(0, 1));
      case (profile)
         0:       begin t_tick = 50; t_ins = 65; t_en = 75; end  // balanced, table half full
         1:       begin t_tick = 30; t_ins = 80; t_en = 90; end  // insert heavy, hits full
         default: begin t_tick = 30; t_ins = 50; t_en = 70; end  // churn on enables and removes
      endcase
      pick = $urandom_range(0, 99);
      if (pick < t_tick) begin
         it.cmd = CMD_TICK;
      end else if (pick < t_ins) begin
         it.cmd = CMD_INSERT;
         kind   = $urandom_range(0, 99);
         if (kind < 8) begin
            it.period = '0;                                   // rejected period
         end else if (kind < 65) begin
            it.period = $urandom_range(1, 12);                // short period, fires often
            it.offset = $urandom_range(0, it.period - 1);
         end else if (kind < 75) begin
            it.period = $urandom_range(1, 12);                // phase never reached
            it.offset = it.period + $urandom_range(0, 5);
         end else if (kind < 92) begin
            // long period aimed a few ticks ahead so it still fires
            it.period = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
            it.offset = ticks_sent + $urandom_range(0, 24);
         end
         // otherwise fully random period and offset
      end else if (pick < t_en) begin
         it.cmd = CMD_SET_ENABLE;
      end else begin
         it.cmd = CMD_REMOVE;
      end
      return it;
   endfunction

   // offers one item and returns once it is taken; valid stays high into the
   // next item when there is no gap so it never drops and rises in one step
   task automatic send_item(input pts_req_type it);
      int gap;
      gap = send_fast ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (it.cmd == CMD_TICK) ticks_sent++;
   endtask

   // result side: random stalls per item, plus two long hold-offs that fill
   // the block up and push back on the request channel
   initial begin
      int hold;
      do @(posedge clock); while (reset);
      forever begin
         if (results_taken == 200 || results_taken == 800) hold = HOLD_CYCLES;
         else if (recv_fast) hold = 0;
         else hold = $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
         if (results_taken % 100 == 0) recv_fast = ($urandom_range(0, 3) == 0);
      end
   end

   // stimulus and verdict
   initial begin
      int profile;
      profile = 0;
      do @(posedge clock); while (reset);

      // directed opening, table empty and tick count zero
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_OFF, 1'b0));
      send_item(make_item(CMD_REMOVE, 4'd0, $urandom(), $urandom(), F_EN, 1'b1));       // unused
      send_item(make_item(CMD_SET_ENABLE, 4'd15, $urandom(), $urandom(), F_OFF, 1'b1)); // unused
      send_item(make_item(CMD_INSERT, 4'd0, 32'd0, 32'd0, F_EN, 1'b0));  // zero period
      send_item(make_item(CMD_INSERT, 4'd0, 32'd1, 32'd0, F_EN, 1'b0));  // fires every tick
      // maximum period with offset not below it: never fires
      send_item(make_item(CMD_INSERT, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, F_EN | F_ONCE,
                          1'b1));
      send_item(make_item(CMD_INSERT, 4'd3, 32'd3, 32'd5, F_EN, 1'b0));  // offset past period
      send_item(make_item(CMD_INSERT, 4'd6, 32'd2, 32'd1, F_EN | F_ONCE, 1'b0)); // run once
      send_item(make_item(CMD_INSERT, 4'd0, 32'd4, 32'd2, F_OFF, 1'b1)); // inserted disabled
      send_item(make_item(CMD_TICK, 4'd15, $urandom(), $urandom(), F_OFF, 1'b1));
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_ONCE, 1'b0));
      send_item(make_item(CMD_SET_ENABLE, 4'd4, 32'd0, 32'd0, F_OFF, 1'b1));
      send_item(make_item(CMD_SET_ENABLE, 4'd3, 32'd0, 32'd0, F_OFF, 1'b1)); // rearm run once
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_OFF, 1'b0));
      send_item(make_item(CMD_SET_ENABLE, 4'd2, 32'd0, 32'd0, F_OFF, 1'b0));
      send_item(make_item(CMD_REMOVE, 4'd0, 32'd0, 32'd0, F_OFF, 1'b0));
      send_item(make_item(CMD_REMOVE, 4'd0, 32'd0, 32'd0, F_OFF, 1'b0)); // already freed
      // long period aimed at the tick after next, lands in the freed slot
      send_item(make_item(CMD_INSERT, 4'd0, 32'hFFFF_FFFE, ticks_sent + 32'd1, F_EN, 1'b0));
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_OFF, 1'b0));
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_OFF, 1'b0));
      // fill the table, the last insert finds it full
      repeat (SLOTS - 4) begin
         send_item(make_item(CMD_INSERT, 4'd0, 32'd7, 32'd3, F_EN, 1'b0));
      end
      send_item(make_item(CMD_TICK, 4'd0, $urandom(), $urandom(), F_OFF, 1'b0));

      // random run, profile and pacing change every few dozen items
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 64 == 0) profile = $urandom_range(0, 2);
         if (n % 100 == 0) send_fast = ($urandom_range(0, 3) == 0);
         send_item(random_item(profile));
      end
      req_valid <= 1'b0;

      // wait for every predicted result, then let the block settle
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && results_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/pts_div.sv
rtl/pts_fifo.sv
rtl/pts_front.sv
rtl/pts_back.sv
rtl/periodic_tick_task_scheduler.sv
rtl/pts_checker.sv
sim/pts_result_checker.sv
sim/tb_periodic_tick_task_scheduler.sv
